/* hdl/uotx_pkg.sv */
// Shared types and constants for the oversampled 8N1 UART transceiver.
// Used by the front, back and top-level modules; depends on nothing.
package uotx_pkg;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_PUSH  = 2'd1,
        FUNC_POP   = 2'd2,
        FUNC_FLUSH = 2'd3
    } uotx_func_t;

    typedef enum logic [1:0] {
        RX_IDLE = 2'd0,
        RX_DATA = 2'd1,
        RX_STOP = 2'd2
    } uotx_rx_phase_t;

    // Bit timing in ticks.
    localparam logic [1:0] TX_TICK_RELOAD = 2'd3;
    localparam logic [2:0] RX_FIRST_WAIT  = 3'd4;
    localparam logic [2:0] RX_BIT_WAIT    = 3'd3;
    localparam logic [3:0] TX_DATA_LAST   = 4'd8;
    localparam logic [3:0] TX_FRAME_LAST  = 4'd9;
    localparam logic [3:0] RX_DATA_BITS   = 4'd8;

    // Result queue in the back part, toward the result channel.
    localparam int QDEPTH = 4;
    localparam int QPW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // Result fields known when the item is accepted.
    typedef struct packed {
        logic       tx_line;
        logic [3:0] rx_count;
        logic       data_valid;
        logic       tx_rejected;
        logic       rx_dropped;
    } uotx_res_t;

    // One queued result item, with the popped byte merged in.
    typedef struct packed {
        uotx_res_t  res;
        logic [7:0] rx_data;
    } uotx_out_t;

endpackage

/* hdl/uotx_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Holds the transmit and receive byte FIFOs; depends on nothing.
module uotx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/uotx_front.sv */
// Front part: decodes each accepted item and updates the FIFO pointers and
// the transmit and receive bit timers. Depends on uotx_pkg.
module uotx_front #(
    parameter int TX_DEPTH = 16,
    parameter int RX_DEPTH = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_take,
    input  uotx_pkg::uotx_func_t        in_func,
    input  logic [7:0]                  in_tx_byte,
    input  logic                        in_rx_line,
    // transmit FIFO memory
    output logic                        tx_we,
    output logic [$clog2(TX_DEPTH)-1:0] tx_waddr,
    output logic [7:0]                  tx_wdata,
    output logic [$clog2(TX_DEPTH)-1:0] tx_raddr,
    input  logic [7:0]                  tx_rdata,
    // receive FIFO memory
    output logic                        rx_we,
    output logic [$clog2(RX_DEPTH)-1:0] rx_waddr,
    output logic [7:0]                  rx_wdata,
    output logic [$clog2(RX_DEPTH)-1:0] rx_raddr,
    // to the back part
    output logic                        res_valid,
    output uotx_pkg::uotx_res_t         res
);
    import uotx_pkg::*;

    localparam int TPW = $clog2(TX_DEPTH);
    localparam int RPW = $clog2(RX_DEPTH);
    localparam int TCW = TPW + 1;
    localparam int RCW = RPW + 1;

    logic [TPW-1:0]  tx_head_reg, tx_head_next, tx_tail_reg, tx_tail_next;
    logic [3:0]      tx_bitpos_reg, tx_bitpos_next;
    logic [1:0]      tx_tick_reg, tx_tick_next, tx_tick_dec;
    logic            tx_level_reg, tx_level_next;
    logic [RPW-1:0]  rx_head_reg, rx_head_next, rx_tail_reg, rx_tail_next;
    uotx_rx_phase_t  rx_phase_reg, rx_phase_next;
    logic [2:0]      rx_tick_reg, rx_tick_next, rx_tick_dec;
    logic [3:0]      rx_bits_reg, rx_bits_next, rx_bits_dec;
    logic [7:0]      rx_shift_reg, rx_shift_next;
    logic            res_valid_reg;
    uotx_res_t       res_reg, res_next, res_base;

    logic [TCW-1:0]  tx_cnt;
    logic [RCW-1:0]  rx_cnt, rx_cnt_next;
    logic [RCW+3:0]  rx_cnt_ext;
    logic            is_tick, tx_busy, rx_full;
    logic [2:0]      tx_bit_idx;

    assign is_tick     = in_take && (in_func == FUNC_TICK);
    assign tx_busy     = tx_head_reg != tx_tail_reg;
    assign tx_tick_dec = tx_tick_reg - 2'd1;
    assign rx_tick_dec = rx_tick_reg - 3'd1;
    assign rx_bits_dec = rx_bits_reg - 4'd1;
    assign tx_bit_idx  = 3'(tx_bitpos_reg - 4'd1);

    assign tx_cnt = (tx_head_reg >= tx_tail_reg)
                  ? TCW'(tx_head_reg) - TCW'(tx_tail_reg)
                  : TCW'(tx_head_reg) + TCW'(TX_DEPTH) - TCW'(tx_tail_reg);
    assign rx_cnt = (rx_head_reg >= rx_tail_reg)
                  ? RCW'(rx_head_reg) - RCW'(rx_tail_reg)
                  : RCW'(rx_head_reg) + RCW'(RX_DEPTH) - RCW'(rx_tail_reg);
    assign rx_cnt_next = (rx_head_next >= rx_tail_next)
                  ? RCW'(rx_head_next) - RCW'(rx_tail_next)
                  : RCW'(rx_head_next) + RCW'(RX_DEPTH) - RCW'(rx_tail_next);
    assign rx_cnt_ext = {4'd0, rx_cnt_next};
    assign rx_full    = rx_cnt >= RCW'(RX_DEPTH - 1);

    // Receive phase: next state.
    always_comb begin
        rx_phase_next = rx_phase_reg;
        if (is_tick) begin
            unique case (rx_phase_reg)
                RX_IDLE: begin
                    if (!in_rx_line) rx_phase_next = RX_DATA;
                end
                RX_DATA: begin
                    if (rx_tick_dec == 3'd0 && rx_bits_dec == 4'd0) rx_phase_next = RX_STOP;
                end
                RX_STOP: begin
                    if (rx_tick_dec == 3'd0) rx_phase_next = RX_IDLE;
                end
                default: rx_phase_next = RX_IDLE;
            endcase
        end
    end

    // Receive phase outputs and the rest of the datapath.
    always_comb begin
        tx_head_next   = tx_head_reg;
        tx_tail_next   = tx_tail_reg;
        tx_bitpos_next = tx_bitpos_reg;
        tx_tick_next   = tx_tick_reg;
        tx_level_next  = tx_level_reg;
        rx_head_next   = rx_head_reg;
        rx_tail_next   = rx_tail_reg;
        rx_tick_next   = rx_tick_reg;
        rx_bits_next   = rx_bits_reg;
        rx_shift_next  = rx_shift_reg;
        tx_we          = 1'b0;
        rx_we          = 1'b0;
        res_base       = '0;

        if (in_take) begin
            case (in_func)
                FUNC_TICK: begin
                    // Transmit timer runs only while a byte is waiting.
                    if (tx_busy) begin
                        tx_tick_next = tx_tick_dec;
                        if (tx_tick_dec == 2'd0) begin
                            if (tx_bitpos_reg == 4'd0) begin
                                tx_level_next = 1'b0;
                            end else if (tx_bitpos_reg <= TX_DATA_LAST) begin
                                tx_level_next = tx_rdata[tx_bit_idx];
                            end else begin
                                tx_level_next = 1'b1;
                                tx_tail_next  = (tx_tail_reg == TPW'(TX_DEPTH - 1))
                                              ? '0 : tx_tail_reg + 1'b1;
                            end
                            tx_bitpos_next = (tx_bitpos_reg >= TX_FRAME_LAST)
                                           ? 4'd0 : tx_bitpos_reg + 4'd1;
                            tx_tick_next   = TX_TICK_RELOAD;
                        end
                    end
                    unique case (rx_phase_reg)
                        RX_IDLE: begin
                            if (!in_rx_line) begin
                                rx_shift_next = 8'd0;
                                rx_tick_next  = RX_FIRST_WAIT;
                                rx_bits_next  = RX_DATA_BITS;
                            end
                        end
                        RX_DATA: begin
                            rx_tick_next = rx_tick_dec;
                            if (rx_tick_dec == 3'd0) begin
                                rx_tick_next  = RX_BIT_WAIT;
                                rx_shift_next = {in_rx_line, rx_shift_reg[7:1]};
                                rx_bits_next  = rx_bits_dec;
                            end
                        end
                        RX_STOP: begin
                            rx_tick_next = rx_tick_dec;
                            if (rx_tick_dec == 3'd0) begin
                                if (rx_full) begin
                                    res_base.rx_dropped = 1'b1;
                                end else begin
                                    rx_we        = 1'b1;
                                    rx_head_next = (rx_head_reg == RPW'(RX_DEPTH - 1))
                                                 ? '0 : rx_head_reg + 1'b1;
                                end
                            end
                        end
                        default: rx_tick_next = rx_tick_reg;
                    endcase
                end
                FUNC_PUSH: begin
                    if (tx_cnt >= TCW'(TX_DEPTH - 1)) begin
                        res_base.tx_rejected = 1'b1;
                    end else begin
                        tx_we        = 1'b1;
                        tx_head_next = (tx_head_reg == TPW'(TX_DEPTH - 1))
                                     ? '0 : tx_head_reg + 1'b1;
                    end
                end
                FUNC_POP: begin
                    // The memory reads rx_tail every cycle; the byte joins the
                    // result item in the back part in the next cycle.
                    if (rx_head_reg != rx_tail_reg) begin
                        res_base.data_valid = 1'b1;
                        rx_tail_next = (rx_tail_reg == RPW'(RX_DEPTH - 1))
                                     ? '0 : rx_tail_reg + 1'b1;
                    end
                end
                FUNC_FLUSH: begin
                    rx_head_next = rx_tail_reg;
                end
                default: rx_head_next = rx_head_reg;
            endcase
        end
        res_base.tx_line = tx_level_next;
    end

    // The count after the item depends on the updated pointers.
    always_comb begin
        res_next          = res_base;
        res_next.rx_count = rx_cnt_ext[3:0];
    end

    assign tx_waddr = tx_head_reg;
    assign tx_wdata = in_tx_byte;
    assign tx_raddr = tx_tail_reg;
    assign rx_waddr = rx_head_reg;
    assign rx_wdata = rx_shift_reg;
    assign rx_raddr = rx_tail_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tx_head_reg   <= '0;
            tx_tail_reg   <= '0;
            tx_bitpos_reg <= 4'd0;
            tx_tick_reg   <= TX_TICK_RELOAD;
            tx_level_reg  <= 1'b1;
            rx_head_reg   <= '0;
            rx_tail_reg   <= '0;
            rx_phase_reg  <= RX_IDLE;
            rx_tick_reg   <= 3'd0;
            rx_bits_reg   <= 4'd0;
            rx_shift_reg  <= 8'd0;
            res_valid_reg <= 1'b0;
        end else begin
            tx_head_reg   <= tx_head_next;
            tx_tail_reg   <= tx_tail_next;
            tx_bitpos_reg <= tx_bitpos_next;
            tx_tick_reg   <= tx_tick_next;
            tx_level_reg  <= tx_level_next;
            rx_head_reg   <= rx_head_next;
            rx_tail_reg   <= rx_tail_next;
            rx_phase_reg  <= rx_phase_next;
            rx_tick_reg   <= rx_tick_next;
            rx_bits_reg   <= rx_bits_next;
            rx_shift_reg  <= rx_shift_next;
            res_valid_reg <= in_take;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_rx_tick_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rx_tick_reg <= RX_FIRST_WAIT)
        else $error("receive tick counter out of range");

    a_tx_bitpos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        tx_bitpos_reg <= TX_FRAME_LAST)
        else $error("transmit bit position out of range");

    a_rx_idle_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        rx_phase_reg == RX_IDLE |-> rx_tick_reg == 3'd0)
        else $error("receive timer running while waiting for start");

    a_tx_idle_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !tx_busy |=> $stable(tx_level_reg) && $stable(tx_bitpos_reg))
        else $error("transmitter moved with an empty FIFO");

endmodule

/* hdl/uotx_back.sv */
// Back part: merges the popped byte into each result item and holds the
// items in a short queue toward the result channel. Depends on uotx_pkg.
module uotx_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                res_valid,
    input  uotx_pkg::uotx_res_t res,
    input  logic [7:0]          rx_rdata,
    output logic                can_take,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,
    output logic [0:0]          m_tuser
);
    import uotx_pkg::*;

    uotx_out_t        q_mem [QDEPTH];
    logic [QPW-1:0]   wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]   q_cnt_reg, q_cnt_next;
    uotx_out_t        entry, head;
    logic             push, pop;

    assign entry.res     = res;
    assign entry.rx_data = res.data_valid ? rx_rdata : 8'd0;

    assign push = res_valid;
    assign pop  = m_tvalid && m_tready;

    // Room must cover the item already on its way from the front.
    assign can_take = (q_cnt_reg + QCW'(res_valid)) < QCW'(QDEPTH);

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        q_cnt_next  = q_cnt_reg + QCW'(push) - QCW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            q_cnt_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            q_cnt_reg  <= q_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= entry;
        end
    end

    assign head     = q_mem[rd_ptr_reg];
    assign m_tvalid = q_cnt_reg != '0;
    assign m_tdata  = {1'b0, head.res.rx_dropped, head.res.tx_rejected,
                       head.res.rx_count, head.rx_data, head.res.tx_line};
    assign m_tuser  = head.res.data_valid;

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> q_cnt_reg < QCW'(QDEPTH))
        else $error("result queue written while full");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        q_cnt_reg <= QCW'(QDEPTH))
        else $error("result queue count out of range");

    a_data_masked: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[8:1] == 8'd0)
        else $error("byte shown on an item without a popped byte");

endmodule

/* hdl/uart_8n1_oversampled_transceiver.sv */
// Top level of the 8N1 UART transceiver with three ticks per bit.
// Instantiates uotx_front, uotx_back and two uotx_ram; depends on uotx_pkg.
//
//  Channel | Direction | tdata (low bit up)                        | tuser
//  s_      | in        | tx_byte[7:0], rx_line[8], zero [15:9]     | func[1:0]
//  m_      | out       | tx_line[0], rx_data[8:1], rx_count[12:9], | rx_data_valid[0]
//          |           | tx_rejected[13], rx_dropped[14], zero[15] |
//
// One item is accepted per cycle while s_tready is high; the front registers its result
// and updates all pointers and bit timers in the cycle of acceptance. The popped byte
// comes from the receive FIFO memory's registered read and joins it in the back part.
// A four-item result queue decouples the two sides; s_tready falls only when that
// queue, counting the item in flight, is full.
// Reset is synchronous; the FIFO memories are not cleared.
module uart_8n1_oversampled_transceiver #(
    parameter int TX_DEPTH = 16,
    parameter int RX_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // tx_byte, rx_line
    input  logic [1:0]  s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // tx_line, rx_data, rx_count, tx_rejected, rx_dropped
    output logic [0:0]  m_tuser    // rx_data_valid
);
    import uotx_pkg::*;

    localparam int TPW = $clog2(TX_DEPTH);
    localparam int RPW = $clog2(RX_DEPTH);

    logic           take;
    logic           tx_we, rx_we;
    logic [TPW-1:0] tx_waddr, tx_raddr;
    logic [RPW-1:0] rx_waddr, rx_raddr;
    logic [7:0]     tx_wdata, tx_rdata, rx_wdata, rx_rdata;
    logic           res_valid, can_take;
    uotx_res_t      res;

    assign s_tready = can_take;
    assign take     = s_tvalid && s_tready;

    uotx_front #(
        .TX_DEPTH (TX_DEPTH),
        .RX_DEPTH (RX_DEPTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_take    (take),
        .in_func    (uotx_func_t'(s_tuser)),
        .in_tx_byte (s_tdata[7:0]),
        .in_rx_line (s_tdata[8]),
        .tx_we      (tx_we),
        .tx_waddr   (tx_waddr),
        .tx_wdata   (tx_wdata),
        .tx_raddr   (tx_raddr),
        .tx_rdata   (tx_rdata),
        .rx_we      (rx_we),
        .rx_waddr   (rx_waddr),
        .rx_wdata   (rx_wdata),
        .rx_raddr   (rx_raddr),
        .res_valid  (res_valid),
        .res        (res)
    );

    uotx_ram #(
        .WIDTH (8),
        .DEPTH (TX_DEPTH)
    ) u_tx_ram (
        .clk   (aclk),
        .we    (tx_we),
        .waddr (tx_waddr),
        .wdata (tx_wdata),
        .raddr (tx_raddr),
        .rdata (tx_rdata)
    );

    uotx_ram #(
        .WIDTH (8),
        .DEPTH (RX_DEPTH)
    ) u_rx_ram (
        .clk   (aclk),
        .we    (rx_we),
        .waddr (rx_waddr),
        .wdata (rx_wdata),
        .raddr (rx_raddr),
        .rdata (rx_rdata)
    );

    uotx_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .rx_rdata  (rx_rdata),
        .can_take  (can_take),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
